FILE: rtl/crc16ws_pkg.sv
// ----------------------------------------------------------------------------
// crc16ws_pkg: shared constants and CRC byte lookup
// Holds the polynomial, field widths and the byte-swapped table function.
// ----------------------------------------------------------------------------
package crc16ws_pkg;

  localparam int unsigned DATA_W     = 24;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MASK_WORDS_DEFAULT = 16;

  localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_MSB   = 16'h8000;
  localparam logic [BYTE_W-1:0] FIRST_BYTE_MASK = 8'd253;

  // Byte-swapped MSB-first CRC of one byte with a zero register.
  function automatic logic [CRC_W-1:0] swapped_entry(input logic [BYTE_W-1:0] idx);
    logic [CRC_W-1:0] v;
    v = {idx, {BYTE_W{1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if ((v & CRC_MSB) != '0) begin
        v = {v[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[CRC_W-2:0], 1'b0};
      end
    end
    return {v[BYTE_W-1:0], v[CRC_W-1:BYTE_W]};
  endfunction

  // Fold one byte into a byte-swapped register.
  function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] idx;
    idx = crc[BYTE_W-1:0] ^ data;
    return swapped_entry(idx) ^ {{BYTE_W{1'b0}}, crc[CRC_W-1:BYTE_W]};
  endfunction

endpackage

FILE: rtl/crc16ws_fold.sv
// ----------------------------------------------------------------------------
// crc16ws_fold: one-word CRC update
// Applies restart and the masking window, then folds three bytes, low first.
// ----------------------------------------------------------------------------
module crc16ws_fold #(
  parameter int unsigned MASKED_WORDS = crc16ws_pkg::MASK_WORDS_DEFAULT,
  parameter int unsigned CNT_W = 5
) (
  input  logic [crc16ws_pkg::CRC_W-1:0]  crc_in,
  input  logic [CNT_W-1:0]               count_in,
  input  logic [crc16ws_pkg::DATA_W-1:0] data_word,
  input  logic                           restart,
  output logic [crc16ws_pkg::CRC_W-1:0]  crc_out,
  output logic [CNT_W-1:0]               count_out
);
  import crc16ws_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MASKED_WORDS);

  logic [CRC_W-1:0]  crc_base;
  logic [CNT_W-1:0]  count_base;
  logic              masked;
  logic [BYTE_W-1:0] byte0;
  logic [CRC_W-1:0]  crc_a;
  logic [CRC_W-1:0]  crc_b;

  always_comb begin
    // Clear state first on restart.
    crc_base   = restart ? '0 : crc_in;
    count_base = restart ? '0 : count_in;
    masked     = (count_base < LIMIT);
    byte0      = data_word[BYTE_W-1:0];
    if (masked) begin
      byte0 = byte0 & FIRST_BYTE_MASK;
    end
    crc_a   = fold_byte(crc_base, byte0);
    crc_b   = fold_byte(crc_a, data_word[2*BYTE_W-1:BYTE_W]);
    crc_out = fold_byte(crc_b, data_word[3*BYTE_W-1:2*BYTE_W]);
    // Saturate at the window length.
    count_out = masked ? count_base + CNT_W'(1) : count_base;
  end

endmodule

FILE: rtl/crc16_word_stream_core.sv
// ----------------------------------------------------------------------------
// crc16_word_stream_core: CRC-16 (0x1021) over a stream of 24-bit words
// Folds three bytes per word and returns the byte-swapped complemented CRC.
// ----------------------------------------------------------------------------
//
//  channel | signals                            | carries
//  --------+------------------------------------+---------------------------
//  input   | in_valid in_ready data_word restart| one word request per item
//  output  | out_valid out_ready check_word     | one check word per item
//
//  One word is taken every cycle while the output is not stalled; a result
//  passes the input register, then the result register, before it is offered,
//  and can leave at the next edge.
//  The rate is set by the combinational fold between the two registers.
//  Reset clears the CRC, the word count and both valid flags.
//  A stalled output holds its result; the input register still takes a new
//  request while the result is waiting, then stalls until the result leaves.
//
module crc16_word_stream_core #(
  parameter int unsigned MASKED_WORDS = crc16ws_pkg::MASK_WORDS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [crc16ws_pkg::DATA_W-1:0] data_word,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crc16ws_pkg::CRC_W-1:0]  check_word
);
  import crc16ws_pkg::*;

  // Counter wide enough to hold the window length itself.
  localparam int unsigned CNT_W = (MASKED_WORDS > 0) ? $clog2(MASKED_WORDS + 1) : 1;

  // Input register
  logic              s1_valid;
  logic [DATA_W-1:0] s1_data;
  logic              s1_restart;

  // Running state
  logic [CRC_W-1:0]  crc_register;
  logic [CNT_W-1:0]  words_seen;
  logic [CRC_W-1:0]  crc_register_next;
  logic [CNT_W-1:0]  words_seen_next;

  logic advance;

  // Move the held request into the result register when it is free or
  // being emptied this cycle.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  crc16ws_fold #(
    .MASKED_WORDS (MASKED_WORDS),
    .CNT_W        (CNT_W)
  ) u_fold (
    .crc_in    (crc_register),
    .count_in  (words_seen),
    .data_word (s1_data),
    .restart   (s1_restart),
    .crc_out   (crc_register_next),
    .count_out (words_seen_next)
  );

  // Capture requests; payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_data    <= data_word;
      s1_restart <= restart;
    end
  end

  // Advance the CRC state and load the result in the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= '0;
      words_seen   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        crc_register <= crc_register_next;
        words_seen   <= words_seen_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      // Store the complement with its bytes swapped.
      check_word <= ~{crc_register_next[BYTE_W-1:0], crc_register_next[CRC_W-1:BYTE_W]};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    words_seen <= CNT_W'(MASKED_WORDS))
    else $error("word count past masking window");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");

  a_crc_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(crc_register) && $stable(words_seen))
    else $error("CRC state moved without a request");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("empty input register not ready");

  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    advance |=> check_word == ~{crc_register[BYTE_W-1:0], crc_register[CRC_W-1:BYTE_W]})
    else $error("check word does not match CRC state");
`endif

endmodule
